// ===== src/primitive_index_generator_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef PRIMITIVE_INDEX_GENERATOR_ASSERT_SVH
`define PRIMITIVE_INDEX_GENERATOR_ASSERT_SVH

// Check on every clock edge outside reset.
`define PIG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("primitive index generator check failed");

// Check on every clock edge, reset included.
`define PIG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("primitive index generator reset check failed");

`endif

// ===== src/pig_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pig_pkg;

  localparam int unsigned IDX_W = 16;
  localparam int unsigned LANES = 4;
  localparam int unsigned LANE_W = 2;
  localparam int unsigned CNT_W = 3;

  // number of addressable vertices
  localparam longint unsigned MAX_VERTICES = 64'd65536;

  // largest index: min(MAX_VERTICES - 1, 65535)
  localparam logic [IDX_W-1:0] IDX_LIMIT =
    (MAX_VERTICES - 64'd1 > 64'd65535) ? 16'hFFFF : IDX_W'(MAX_VERTICES - 64'd1);

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0] REG_PRIM_MODE = 1'b0;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_POINTS = 2'd0,
    MODE_LIST   = 2'd1,
    MODE_LOOP   = 2'd2,
    MODE_STRIP  = 2'd3
  } prim_mode_t;

  // indices caused by one vertex, and the lane that holds the last one
  typedef struct packed {
    idx_t [LANES-1:0]  idx;
    logic [LANE_W-1:0] last_lane;
  } pig_bundle_t;

  // saturating clamp of a one-bit-grown sum
  function automatic idx_t sat_idx(input logic [IDX_W:0] s);
    sat_idx = (s > {1'b0, IDX_LIMIT}) ? IDX_LIMIT : s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/pig_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// vertex channel
interface pig_vtx_if;
  logic valid;
  logic ready;
  logic boundary_end;
  logic shape_end;

  modport source (output valid, output boundary_end, output shape_end, input ready);
  modport sink (input valid, input boundary_end, input shape_end, output ready);
endinterface

// index channel
interface pig_idx_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_index;
  logic        run_last;

  modport source (output valid, output vertex_index, output run_last, input ready);
  modport sink (input valid, input vertex_index, input run_last, output ready);
endinterface
`default_nettype wire

// ===== src/pig_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pig_cfg
  import pig_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output prim_mode_t              prim_mode
);

  logic reg_sel;

  // word address decode
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_PRIM_MODE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prim_mode <= MODE_POINTS;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      prim_mode <= prim_mode_t'(pwdata[1:0]);
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[1:0] = prim_mode;
    end
  end

endmodule
`default_nettype wire

// ===== src/pig_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pig_gen
  import pig_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire prim_mode_t prim_mode,
  pig_vtx_if.sink         vtx,
  input  wire logic       bnd_take,
  output logic            bnd_valid,
  output pig_bundle_t     bnd
);

  idx_t        pos;
  idx_t        base;
  idx_t        pos_next;
  idx_t        base_next;
  idx_t        cur;
  idx_t        prev;
  idx_t        cur_inc;
  idx_t        pos_dec;
  logic        bnd_end;
  logic        accept;
  logic        load;
  logic [CNT_W-1:0] cnt;
  pig_bundle_t bnd_next;

  assign vtx.ready = !bnd_valid || bnd_take;
  assign accept    = vtx.valid && vtx.ready;
  assign bnd_end   = vtx.boundary_end || vtx.shape_end;

  // current, previous and next index of this boundary
  assign pos_dec = pos - idx_t'(1);
  assign cur     = sat_idx({1'b0, base} + {1'b0, pos});
  assign prev    = (pos == '0) ? cur : sat_idx({1'b0, base} + {1'b0, pos_dec});
  assign cur_inc = sat_idx({1'b0, cur} + {{IDX_W{1'b0}}, 1'b1});

  // index list for the vertex
  always_comb begin
    cnt = '0;
    for (int i = 0; i < LANES; i++) begin
      bnd_next.idx[i] = cur;
    end
    case (prim_mode)
      MODE_POINTS: begin
        cnt = CNT_W'(1);
      end
      MODE_LIST: begin
        if (pos[0]) begin
          bnd_next.idx[0] = prev;
          cnt = CNT_W'(2);
        end
      end
      MODE_LOOP: begin
        if (pos != '0) begin
          bnd_next.idx[0] = prev;
          if (bnd_end) begin
            bnd_next.idx[3] = base;
            cnt = CNT_W'(4);
          end else begin
            cnt = CNT_W'(2);
          end
        end else if (bnd_end) begin
          bnd_next.idx[1] = base;
          cnt = CNT_W'(2);
        end
      end
      default: begin
        if (pos != '0) begin
          bnd_next.idx[0] = prev;
          cnt = CNT_W'(2);
        end
      end
    endcase
    bnd_next.last_lane = LANE_W'(cnt - CNT_W'(1));
  end

  assign load = accept && (cnt != '0);

  // boundary counters
  always_comb begin
    pos_next  = pos;
    base_next = base;
    if (vtx.shape_end) begin
      pos_next  = '0;
      base_next = '0;
    end else if (bnd_end) begin
      pos_next  = '0;
      base_next = cur_inc;
    end else begin
      pos_next  = sat_idx({1'b0, pos} + {{IDX_W{1'b0}}, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      base <= '0;
    end else if (accept) begin
      pos  <= pos_next;
      base <= base_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_valid <= 1'b0;
    end else if (load) begin
      bnd_valid <= 1'b1;
    end else if (bnd_take) begin
      bnd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd <= bnd_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/pig_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pig_ser
  import pig_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        bnd_valid,
  input  wire pig_bundle_t bnd,
  output logic             bnd_take,
  pig_idx_if.source        idx
);

  logic              out_valid;
  logic [LANE_W-1:0] lane;
  pig_bundle_t       held;
  logic              fire;
  logic              done;

  assign fire     = out_valid && idx.ready;
  assign done     = fire && (lane == held.last_lane);
  assign bnd_take = bnd_valid && (!out_valid || done);

  assign idx.valid        = out_valid;
  assign idx.vertex_index = held.idx[lane];
  assign idx.run_last     = (lane == held.last_lane);

  // one word per cycle out of the held list while idx is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lane      <= '0;
    end else if (bnd_take) begin
      out_valid <= 1'b1;
      lane      <= '0;
    end else if (done) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      lane      <= lane + LANE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_take) begin
      held <= bnd;
    end
  end

endmodule
`default_nettype wire

// ===== src/primitive_index_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Primitive index generator.
// vtx: one word per vertex with boundary_end / shape_end flags.
// idx: vertex indices for the mode in register 0 (0 points, 1 line list,
//      2 line loop, 3 line strip), run_last marks the last index of a vertex.
// Mode is written over the APB port while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
// Throughput: one index word per cycle while idx is ready; a vertex makes
// one index for points, two for line pairs, four for a loop close, all
// sent over the single index output port. A vertex that makes no index
// is taken without sending a word.
// A vertex is taken while the previous vertex's indices are still being
// drained: the list register and the output register form two stages.
// When idx stalls, the current word holds and vtx.ready drops once both
// stages are full.
// Reset (rst, synchronous) clears mode to points, both boundary counters
// and all valid flags.
module primitive_index_generator
  import pig_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  pig_vtx_if.sink                 vtx,
  pig_idx_if.source               idx,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  prim_mode_t  prim_mode;
  logic        bnd_valid;
  logic        bnd_take;
  pig_bundle_t bnd;

  pig_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .prim_mode (prim_mode)
  );

  pig_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .prim_mode (prim_mode),
    .vtx       (vtx),
    .bnd_take  (bnd_take),
    .bnd_valid (bnd_valid),
    .bnd       (bnd)
  );

  pig_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .bnd_valid (bnd_valid),
    .bnd       (bnd),
    .bnd_take  (bnd_take),
    .idx       (idx)
  );

endmodule
`default_nettype wire

// ===== src/pig_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "primitive_index_generator_assert.svh"
module pig_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        vtx_ready,
  input wire logic        idx_valid,
  input wire logic        idx_ready,
  input wire logic [15:0] vertex_index,
  input wire logic        run_last,
  input wire logic        pready
);

  // stalled index word holds
  `PIG_ASSERT(a_idx_hold, idx_valid && !idx_ready |=> idx_valid && $stable(vertex_index) && $stable(run_last))
  // nothing comes out right after reset
  `PIG_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !idx_valid)
  // idle output means input is open
  `PIG_ASSERT(a_ready_idle, !idx_valid |-> vtx_ready)
  // rest of a vertex's list is already buffered
  `PIG_ASSERT(a_run_cont, idx_valid && idx_ready && !run_last |=> idx_valid)
  // configuration never waits
  `PIG_ASSERT(a_pready, pready)

endmodule

bind primitive_index_generator pig_checker u_pig_checker (
  .clk          (clk),
  .rst          (rst),
  .vtx_ready    (vtx.ready),
  .idx_valid    (idx.valid),
  .idx_ready    (idx.ready),
  .vertex_index (idx.vertex_index),
  .run_last     (idx.run_last),
  .pready       (pready)
);
`default_nettype wire
